// File: hw/rtl/oifs_pkg.sv
`default_nettype none
package oifs_pkg;

	// Register map and reset value.
	localparam int          ADDR_W         = 4;
	localparam logic        REG_GRAV_PARAM = 1'b0;
	localparam int          MU_W           = 63;
	localparam logic [62:0] MU_RESET       = 63'd398600441800000;

	// Datapath widths.
	localparam int KIN_W  = 47;
	localparam int RQ_W   = 48;
	localparam int DIV_W  = 95;
	localparam int XMAG_W = 34;
	localparam int UNIT_W = 30;

	// Stage map of the pipeline.
	localparam int S_SIDE    = 3;
	localparam int S_SQ_LO   = 4;
	localparam int S_SQ_HI   = 51;
	localparam int S_RD_LO   = 52;
	localparam int S_RD_HI   = 146;
	localparam int S_XMAG    = 7;
	localparam int S_XD_LO   = 8;
	localparam int S_XD_HI   = 102;
	localparam int S_XCLAMP  = 103;
	localparam int S_JOIN    = 147;
	localparam int S_OUT     = 148;
	localparam int LATENCY   = S_OUT;

	// Values that ride along the pipeline beside the arithmetic units.
	typedef struct packed {
		logic                   zero;
		logic [KIN_W-1:0]       kin;
		logic [2:0][63:0]       h;
		logic [2:0][31:0]       pm;
		logic [2:0]             psign;
	} side_t;

endpackage
`default_nettype wire

// File: hw/rtl/orbit_invariants_from_state_core.sv
`default_nettype none
// Orbit invariants from one Cartesian state vector.
//
// An item (pos_x/y/z in integer metres, vel_x/y/z in Q16.16 m/s) is taken at a
// rising edge where start is high and busy is low. busy is always low, so a new
// item may enter on every clock cycle. Items are fully independent.
//
// Each item yields one result: specific energy and angular momentum in Q47.16
// and the eccentricity vector in Q3.28, plus a fault flag for zero radius or
// any saturated output. The result is on the output ports for exactly one
// cycle, marked by done, after the item has passed through every stage.
// The receiver cannot stall the block, and nothing inside ever holds.
//
// The latency is set by the chain of a 48-stage square root for the radius
// (one result bit per stage) followed by a 95-stage restoring divider that
// divides by that radius (one quotient bit per stage); the cross-product
// division by grav_param runs beside it in another 95-stage divider.
//
// grav_param is written through the APB-style port at byte address 0 and may
// only be changed while no item is in flight. Reset clears all valid bits of
// the pipeline and restores grav_param to its reset value.
module orbit_invariants_from_state_core (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire signed [31:0] pos_x,
	input  wire signed [31:0] pos_y,
	input  wire signed [31:0] pos_z,
	input  wire signed [31:0] vel_x,
	input  wire signed [31:0] vel_y,
	input  wire signed [31:0] vel_z,
	output logic              done,
	output logic signed [63:0] energy,
	output logic signed [63:0] ang_mom_x,
	output logic signed [63:0] ang_mom_y,
	output logic signed [63:0] ang_mom_z,
	output logic signed [31:0] ecc_vec_x,
	output logic signed [31:0] ecc_vec_y,
	output logic signed [31:0] ecc_vec_z,
	output logic              fault,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire [oifs_pkg::ADDR_W-1:0] paddr,
	input  wire [63:0]        pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

	localparam int MU_W   = oifs_pkg::MU_W;
	localparam int RQ_W   = oifs_pkg::RQ_W;
	localparam int DIV_W  = oifs_pkg::DIV_W;
	localparam int XMAG_W = oifs_pkg::XMAG_W;
	localparam int UNIT_W = oifs_pkg::UNIT_W;

	localparam logic signed [95:0] EN_FLOOR = -(96'sd1 <<< 63);
	localparam logic signed [35:0] ECC_MAX  = 36'sd2147483647;
	localparam logic signed [35:0] ECC_MIN  = -36'sd2147483648;

	// Configuration register.
	logic [MU_W-1:0] mu_q;
	logic [MU_W-1:0] mu_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= oifs_pkg::MU_RESET;
		end else if (psel && penable && pwrite && pready &&
				paddr[oifs_pkg::ADDR_W-1] == oifs_pkg::REG_GRAV_PARAM) begin
			mu_q <= pwdata[MU_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[oifs_pkg::ADDR_W-1] == oifs_pkg::REG_GRAV_PARAM) begin
			prdata = {1'b0, mu_q};
		end
	end

	assign pready = 1'b1;
	// A zero parameter behaves as one so the divider never sees a zero divisor.
	assign mu_eff = (mu_q == '0) ? MU_W'(1) : mu_q;

	// The pipeline never holds, so the block is always ready.
	assign busy = 1'b0;

	// Valid bits, one per stage.
	logic [oifs_pkg::S_OUT:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[oifs_pkg::S_OUT-1:1], start & ~busy};
		end
	end

	assign done = vld_s[oifs_pkg::S_OUT];

	// Stage 1: input registers.
	logic signed [31:0] pos_s1 [3];
	logic signed [31:0] vel_s1 [3];

	always_ff @(posedge clk) begin
		pos_s1[0] <= pos_x;
		pos_s1[1] <= pos_y;
		pos_s1[2] <= pos_z;
		vel_s1[0] <= vel_x;
		vel_s1[1] <= vel_y;
		vel_s1[2] <= vel_z;
	end

	// Stage 2: squares and the cross-product terms of r x v.
	logic signed [63:0] ppos_s2 [3];
	logic signed [63:0] pvel_s2 [3];
	logic signed [63:0] hp_s2   [3];
	logic signed [63:0] hn_s2   [3];
	logic signed [31:0] pos_s2  [3];
	logic signed [31:0] vel_s2  [3];

	for (genvar i = 0; i < 3; i++) begin : g_s2
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		always_ff @(posedge clk) begin
			ppos_s2[i] <= pos_s1[i] * pos_s1[i];
			pvel_s2[i] <= vel_s1[i] * vel_s1[i];
			hp_s2[i]   <= pos_s1[J] * vel_s1[K];
			hn_s2[i]   <= pos_s1[K] * vel_s1[J];
			pos_s2[i]  <= pos_s1[i];
			vel_s2[i]  <= vel_s1[i];
		end
	end

	// Stage 3: radius squared, kinetic term, angular momentum.
	logic [63:0]          r2_s3;
	logic signed [31:0]   vel_s3 [3];
	oifs_pkg::side_t      side_s [oifs_pkg::S_SIDE:oifs_pkg::S_JOIN];
	logic [63:0]          v2_sum;

	assign v2_sum = 64'(pvel_s2[0]) + 64'(pvel_s2[1]) + 64'(pvel_s2[2]);

	always_ff @(posedge clk) begin
		r2_s3 <= 64'(ppos_s2[0]) + 64'(ppos_s2[1]) + 64'(ppos_s2[2]);
		side_s[oifs_pkg::S_SIDE].kin  <= v2_sum[63:17];
		side_s[oifs_pkg::S_SIDE].zero <= (pos_s2[0] == '0) && (pos_s2[1] == '0) &&
				(pos_s2[2] == '0);
		for (int i = 0; i < 3; i++) begin
			side_s[oifs_pkg::S_SIDE].h[i]     <= 64'(hp_s2[i] - hn_s2[i]);
			side_s[oifs_pkg::S_SIDE].pm[i]    <= pos_s2[i][31] ? 32'(-pos_s2[i]) : pos_s2[i];
			side_s[oifs_pkg::S_SIDE].psign[i] <= pos_s2[i][31];
			vel_s3[i] <= vel_s2[i];
		end
	end

	for (genvar k = oifs_pkg::S_SIDE + 1; k <= oifs_pkg::S_JOIN; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_s[k] <= side_s[k-1];
		end
	end

	// Square root of r2 * 2^32, one result bit per stage, most significant first.
	logic [95:0]     sq_rem_s [oifs_pkg::S_SQ_LO:oifs_pkg::S_SQ_HI];
	logic [RQ_W-1:0] sq_res_s [oifs_pkg::S_SQ_LO:oifs_pkg::S_SQ_HI];

	for (genvar k = oifs_pkg::S_SQ_LO; k <= oifs_pkg::S_SQ_HI; k++) begin : g_sq
		localparam int B = oifs_pkg::S_SQ_HI - k;
		logic [95:0]     rem_in;
		logic [RQ_W-1:0] res_in;
		logic [95:0]     trial;
		if (k == oifs_pkg::S_SQ_LO) begin : g_first
			assign rem_in = {r2_s3, 32'd0};
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = sq_rem_s[k-1];
			assign res_in = sq_res_s[k-1];
		end
		assign trial = ({48'd0, res_in} << (B + 1)) | (96'd1 << (2 * B));
		always_ff @(posedge clk) begin
			if (rem_in >= trial) begin
				sq_rem_s[k] <= rem_in - trial;
				sq_res_s[k] <= res_in | (RQ_W'(1) << B);
			end else begin
				sq_rem_s[k] <= rem_in;
				sq_res_s[k] <= res_in;
			end
		end
	end

	// Dividers by the radius: lane 0 gives mu / |r|, lanes 1 to 3 the unit vector.
	// Each word starts as the numerator and fills with quotient bits from below.
	logic [DIV_W-1:0] dw_s  [oifs_pkg::S_RD_LO:oifs_pkg::S_RD_HI][4];
	logic [RQ_W-1:0]  dr_s  [oifs_pkg::S_RD_LO:oifs_pkg::S_RD_HI][4];
	logic [RQ_W-1:0]  drq_s [oifs_pkg::S_RD_LO:oifs_pkg::S_RD_HI];
	logic [DIV_W-1:0] rd_init [4];

	always_comb begin
		rd_init[0] = {mu_eff, 32'd0};
		for (int l = 0; l < 3; l++) begin
			rd_init[l+1] = {19'd0, side_s[oifs_pkg::S_SQ_HI].pm[l], 44'd0};
		end
	end

	for (genvar k = oifs_pkg::S_RD_LO; k <= oifs_pkg::S_RD_HI; k++) begin : g_rd
		logic [RQ_W-1:0] d_in;
		if (k == oifs_pkg::S_RD_LO) begin : g_first
			assign d_in = sq_res_s[oifs_pkg::S_SQ_HI];
		end else begin : g_next
			assign d_in = drq_s[k-1];
		end
		always_ff @(posedge clk) begin
			drq_s[k] <= d_in;
		end
		for (genvar l = 0; l < 4; l++) begin : g_lane
			logic [DIV_W-1:0] w_in;
			logic [RQ_W-1:0]  r_in;
			logic [RQ_W:0]    t;
			if (k == oifs_pkg::S_RD_LO) begin : g_first
				assign w_in = rd_init[l];
				assign r_in = '0;
			end else begin : g_next
				assign w_in = dw_s[k-1][l];
				assign r_in = dr_s[k-1][l];
			end
			assign t = {r_in, w_in[DIV_W-1]};
			always_ff @(posedge clk) begin
				if (t >= {1'b0, d_in}) begin
					dr_s[k][l] <= RQ_W'(t - {1'b0, d_in});
					dw_s[k][l] <= {w_in[DIV_W-2:0], 1'b1};
				end else begin
					dr_s[k][l] <= t[RQ_W-1:0];
					dw_s[k][l] <= {w_in[DIV_W-2:0], 1'b0};
				end
			end
		end
	end

	// Cross product v x h, built from 32-bit partial products.
	logic signed [63:0] xah_s4 [3];
	logic signed [64:0] xal_s4 [3];
	logic signed [63:0] xbh_s4 [3];
	logic signed [64:0] xbl_s4 [3];
	logic signed [95:0] pa_s5  [3];
	logic signed [95:0] pb_s5  [3];
	logic signed [95:0] c_s6   [3];
	logic [DIV_W-1:0]   cm_s7  [3];
	logic [2:0]         cs_s   [oifs_pkg::S_XMAG:oifs_pkg::S_RD_HI];

	for (genvar i = 0; i < 3; i++) begin : g_cross
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		always_ff @(posedge clk) begin
			xah_s4[i] <= vel_s3[J] * $signed(side_s[oifs_pkg::S_SIDE].h[K][63:32]);
			xal_s4[i] <= vel_s3[J] * $signed({1'b0, side_s[oifs_pkg::S_SIDE].h[K][31:0]});
			xbh_s4[i] <= vel_s3[K] * $signed(side_s[oifs_pkg::S_SIDE].h[J][63:32]);
			xbl_s4[i] <= vel_s3[K] * $signed({1'b0, side_s[oifs_pkg::S_SIDE].h[J][31:0]});
			pa_s5[i]  <= $signed({xah_s4[i], 32'd0}) + xal_s4[i];
			pb_s5[i]  <= $signed({xbh_s4[i], 32'd0}) + xbl_s4[i];
			c_s6[i]   <= pa_s5[i] - pb_s5[i];
			cm_s7[i]  <= c_s6[i][95] ? DIV_W'(-c_s6[i]) : DIV_W'(c_s6[i]);
			cs_s[oifs_pkg::S_XMAG][i] <= c_s6[i][95];
		end
	end

	for (genvar k = oifs_pkg::S_XMAG + 1; k <= oifs_pkg::S_RD_HI; k++) begin : g_csign
		always_ff @(posedge clk) begin
			cs_s[k] <= cs_s[k-1];
		end
	end

	// Dividers of |v x h| by grav_param.
	logic [DIV_W-1:0] cw_s [oifs_pkg::S_XD_LO:oifs_pkg::S_XD_HI][3];
	logic [MU_W-1:0]  cr_s [oifs_pkg::S_XD_LO:oifs_pkg::S_XD_HI][3];

	for (genvar k = oifs_pkg::S_XD_LO; k <= oifs_pkg::S_XD_HI; k++) begin : g_xd
		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [DIV_W-1:0] w_in;
			logic [MU_W-1:0]  r_in;
			logic [MU_W:0]    t;
			if (k == oifs_pkg::S_XD_LO) begin : g_first
				assign w_in = cm_s7[l];
				assign r_in = '0;
			end else begin : g_next
				assign w_in = cw_s[k-1][l];
				assign r_in = cr_s[k-1][l];
			end
			assign t = {r_in, w_in[DIV_W-1]};
			always_ff @(posedge clk) begin
				if (t >= {1'b0, mu_eff}) begin
					cr_s[k][l] <= MU_W'(t - {1'b0, mu_eff});
					cw_s[k][l] <= {w_in[DIV_W-2:0], 1'b1};
				end else begin
					cr_s[k][l] <= t[MU_W-1:0];
					cw_s[k][l] <= {w_in[DIV_W-2:0], 1'b0};
				end
			end
		end
	end

	// Cross term in Q.28. Anything at or above 2^33 saturates in the end
	// whatever the unit term is, so it is clamped to 2^33 before the delay line.
	logic [XMAG_W-1:0] cq_s [oifs_pkg::S_XCLAMP:oifs_pkg::S_RD_HI][3];

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			if (|cw_s[oifs_pkg::S_XD_HI][l][DIV_W-1:37]) begin
				cq_s[oifs_pkg::S_XCLAMP][l] <= XMAG_W'(1) << 33;
			end else begin
				cq_s[oifs_pkg::S_XCLAMP][l] <= {1'b0, cw_s[oifs_pkg::S_XD_HI][l][36:4]};
			end
		end
	end

	for (genvar k = oifs_pkg::S_XCLAMP + 1; k <= oifs_pkg::S_RD_HI; k++) begin : g_cq
		always_ff @(posedge clk) begin
			cq_s[k] <= cq_s[k-1];
		end
	end

	// Join stage: exact energy and eccentricity differences.
	logic signed [95:0] en_diff_s147;
	logic signed [35:0] ed_s147 [3];

	always_ff @(posedge clk) begin
		en_diff_s147 <= $signed({49'd0, side_s[oifs_pkg::S_RD_HI].kin}) -
				$signed({1'b0, dw_s[oifs_pkg::S_RD_HI][0]});
	end

	for (genvar l = 0; l < 3; l++) begin : g_join
		logic signed [35:0] c_val;
		logic signed [35:0] u_val;
		logic [UNIT_W-1:0]  u_mag;
		assign u_mag = side_s[oifs_pkg::S_RD_HI].zero ? '0 :
				dw_s[oifs_pkg::S_RD_HI][l+1][UNIT_W-1:0];
		assign c_val = cs_s[oifs_pkg::S_RD_HI][l] ?
				-$signed({2'b00, cq_s[oifs_pkg::S_RD_HI][l]}) :
				$signed({2'b00, cq_s[oifs_pkg::S_RD_HI][l]});
		assign u_val = side_s[oifs_pkg::S_RD_HI].psign[l] ?
				-$signed({6'd0, u_mag}) : $signed({6'd0, u_mag});
		always_ff @(posedge clk) begin
			ed_s147[l] <= c_val - u_val;
		end
	end

	// Output stage: saturation and the fault flag.
	logic               en_sat;
	logic [2:0]         ec_hi;
	logic [2:0]         ec_lo;
	logic signed [63:0] energy_s148;
	logic signed [63:0] h_s148 [3];
	logic signed [31:0] ecc_s148 [3];
	logic               fault_s148;

	always_comb begin
		en_sat = en_diff_s147 < EN_FLOOR;
		for (int l = 0; l < 3; l++) begin
			ec_hi[l] = ed_s147[l] > ECC_MAX;
			ec_lo[l] = ed_s147[l] < ECC_MIN;
		end
	end

	always_ff @(posedge clk) begin
		if (side_s[oifs_pkg::S_JOIN].zero || en_sat) begin
			energy_s148 <= 64'sh8000_0000_0000_0000;
		end else begin
			energy_s148 <= en_diff_s147[63:0];
		end
		for (int l = 0; l < 3; l++) begin
			h_s148[l] <= side_s[oifs_pkg::S_JOIN].h[l];
			if (ec_hi[l]) begin
				ecc_s148[l] <= 32'sh7FFF_FFFF;
			end else if (ec_lo[l]) begin
				ecc_s148[l] <= 32'sh8000_0000;
			end else begin
				ecc_s148[l] <= ed_s147[l][31:0];
			end
		end
		fault_s148 <= side_s[oifs_pkg::S_JOIN].zero | en_sat | (|ec_hi) | (|ec_lo);
	end

	assign energy    = energy_s148;
	assign ang_mom_x = h_s148[0];
	assign ang_mom_y = h_s148[1];
	assign ang_mom_z = h_s148[2];
	assign ecc_vec_x = ecc_s148[0];
	assign ecc_vec_y = ecc_s148[1];
	assign ecc_vec_z = ecc_s148[2];
	assign fault     = fault_s148;

endmodule
`default_nettype wire

// File: hw/rtl/oifs_checker.sv
`default_nettype none
module oifs_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               start,
	input wire               busy,
	input wire signed [31:0] pos_x,
	input wire signed [31:0] pos_y,
	input wire signed [31:0] pos_z,
	input wire signed [31:0] vel_x,
	input wire signed [31:0] vel_y,
	input wire signed [31:0] vel_z,
	input wire               done,
	input wire signed [63:0] energy,
	input wire signed [63:0] ang_mom_x,
	input wire signed [63:0] ang_mom_y,
	input wire signed [63:0] ang_mom_z,
	input wire signed [31:0] ecc_vec_x,
	input wire signed [31:0] ecc_vec_y,
	input wire signed [31:0] ecc_vec_z,
	input wire               fault,
	input wire               psel,
	input wire               penable,
	input wire               pwrite,
	input wire [oifs_pkg::ADDR_W-1:0] paddr,
	input wire [63:0]        pwdata,
	input wire [63:0]        prdata,
	input wire               pready
);

	localparam int LAT   = oifs_pkg::LATENCY;
	localparam int CYC_W = $clog2(LAT + 1);

	// Cycles since reset release, so that look-backs never reach into reset.
	logic [CYC_W-1:0] cyc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc_q <= '0;
		end else if (cyc_q != CYC_W'(LAT)) begin
			cyc_q <= cyc_q + CYC_W'(1);
		end
	end

	// Every accepted item gives exactly one result, a fixed number of cycles later.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(cyc_q == CYC_W'(LAT)) |-> (done == $past(start && !busy, LAT)))
		else $error("result strobe does not match an accepted item");

	// A position at the origin always reports the fault, the energy floor and zero angular momentum.
	a_zero_radius: assert property (@(posedge clk) disable iff (!arst_n)
		((cyc_q == CYC_W'(LAT)) &&
		 $past(start && !busy && pos_x == 0 && pos_y == 0 && pos_z == 0, LAT))
		|-> (fault && energy == 64'sh8000_0000_0000_0000 &&
			ang_mom_x == 0 && ang_mom_y == 0 && ang_mom_z == 0))
		else $error("zero radius result is wrong");

	// A written grav_param reads back on the next cycle.
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready &&
		 paddr[oifs_pkg::ADDR_W-1] == oifs_pkg::REG_GRAV_PARAM)
		|=> ((paddr[oifs_pkg::ADDR_W-1] != oifs_pkg::REG_GRAV_PARAM) ||
			(prdata == {1'b0, $past(pwdata[62:0])})))
		else $error("grav_param read back differs from the value written");

endmodule

bind orbit_invariants_from_state_core oifs_checker u_oifs_checker (.*);
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
`default_nettype none

module tb;

	localparam int              ADDR_W         = oifs_pkg::ADDR_W;
	localparam int              MU_W           = oifs_pkg::MU_W;
	localparam logic [MU_W-1:0] MU_RESET       = oifs_pkg::MU_RESET;
	localparam logic            REG_GRAV_PARAM = oifs_pkg::REG_GRAV_PARAM;
	localparam int              LATENCY        = oifs_pkg::LATENCY;

	// One state vector as it is presented on the input ports.
	typedef struct packed {
		logic [31:0] px, py, pz;
		logic [31:0] vx, vy, vz;
	} state_vec_t;

	// One result as it leaves the block.
	typedef struct packed {
		logic [63:0] energy;
		logic [63:0] hx, hy, hz;
		logic [31:0] ex, ey, ez;
		logic        fault;
	} invariants_t;

	localparam int CLK_HI       = 6;
	localparam int CLK_LO       = 6;
	localparam int RESET_CYCLES = 9;
	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 290;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;

	wire         busy, done, fault, pready;
	wire  [63:0] energy, ang_mom_x, ang_mom_y, ang_mom_z, prdata;
	wire  [31:0] ecc_vec_x, ecc_vec_y, ecc_vec_z;

	orbit_invariants_from_state_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
		.done(done), .energy(energy),
		.ang_mom_x(ang_mom_x), .ang_mom_y(ang_mom_y), .ang_mom_z(ang_mom_z),
		.ecc_vec_x(ecc_vec_x), .ecc_vec_y(ecc_vec_y), .ecc_vec_z(ecc_vec_z),
		.fault(fault),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#CLK_HI clk = 1'b1;
		#CLK_LO clk = 1'b0;
	end

	// Our copy of the gravitational parameter, tracked through every write.
	logic [MU_W-1:0] mu_model = MU_RESET;

	state_vec_t  state_q[$];        // items waiting for the driver
	invariants_t invariants_q[$];   // predicted results not yet seen
	int          mismatches = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          faults_seen = 0;
	int          idle_cycles = 0;
	int          phases_run = 0;

	// Predict one result. Everything is exact integer math at wide widths:
	// the square root and all divisions truncate, outputs saturate.
	function automatic invariants_t compute_invariants(state_vec_t s, logic [MU_W-1:0] mu_reg);
		logic signed [63:0]  r[3];
		logic signed [63:0]  v[3];
		logic signed [63:0]  h[3];
		logic signed [127:0] hw;
		logic [63:0]         r2, v2, kin, rq, cand, mu, rmag;
		logic [127:0]        rad2, pot, diff, um;
		logic signed [159:0] c, q, u, e;
		logic [159:0]        cm;
		logic [31:0]         ecc[3];
		int                  j, k;
		invariants_t         o;
		o.fault = 1'b0;
		mu = (mu_reg == '0) ? 64'd1 : {1'b0, mu_reg};
		r[0] = {{32{s.px[31]}}, s.px};
		r[1] = {{32{s.py[31]}}, s.py};
		r[2] = {{32{s.pz[31]}}, s.pz};
		v[0] = {{32{s.vx[31]}}, s.vx};
		v[1] = {{32{s.vy[31]}}, s.vy};
		v[2] = {{32{s.vz[31]}}, s.vz};
		r2 = '0;
		v2 = '0;
		for (int i = 0; i < 3; i++) begin
			r2 = r2 + 64'(r[i] * r[i]);
			v2 = v2 + 64'(v[i] * v[i]);
		end
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			hw = r[j] * v[k] - r[k] * v[j];
			h[i] = hw[63:0];
		end
		kin = v2 >> 17;
		// Radius in Q.16, found one bit at a time from the top.
		rad2 = {r2, 64'b0} >> 32;
		rq = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = rq | (64'd1 << b);
			if ({64'b0, cand} * {64'b0, cand} <= rad2)
				rq = cand;
		end
		if (r2 == '0) begin
			o.fault = 1'b1;
			o.energy = 64'h8000_0000_0000_0000;
		end else begin
			pot = {32'b0, mu, 32'b0} / {64'b0, rq};
			if (pot <= {64'b0, kin}) begin
				o.energy = kin - pot[63:0];
			end else begin
				diff = pot - {64'b0, kin};
				if (diff > 128'h8000_0000_0000_0000) begin
					o.fault = 1'b1;
					o.energy = 64'h8000_0000_0000_0000;
				end else begin
					o.energy = 64'd0 - diff[63:0];
				end
			end
		end
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			c = v[j] * h[k] - v[k] * h[j];
			cm = (c < 0) ? -c : c;
			q = (cm / {96'b0, mu}) >> 4;
			if (c < 0)
				q = -q;
			u = '0;
			if (r2 != '0) begin
				rmag = (r[i] < 0) ? -r[i] : r[i];
				um = ({64'b0, rmag} << 44) / {64'b0, rq};
				u = (r[i] < 0) ? -$signed({32'b0, um}) : $signed({32'b0, um});
			end
			e = q - u;
			if (e > 160'sd2147483647) begin
				o.fault = 1'b1;
				ecc[i] = 32'h7fff_ffff;
			end else if (e < -160'sd2147483648) begin
				o.fault = 1'b1;
				ecc[i] = 32'h8000_0000;
			end else begin
				ecc[i] = e[31:0];
			end
		end
		o.hx = h[0];
		o.hy = h[1];
		o.hz = h[2];
		o.ex = ecc[0];
		o.ey = ecc[1];
		o.ez = ecc[2];
		return o;
	endfunction

	// The driver sends items in bursts of random length with random gaps.
	// An item counts as taken at the edge where start is high and busy low,
	// and its result is predicted right there with the current parameter.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		state_vec_t nxt;
		logic       taken;
		logic       present;
		taken = arst_n && start && !busy;
		if (taken) begin
			invariants_q.push_back(compute_invariants(
				{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z}, mu_model));
			items_sent++;
		end
		present = 1'b0;
		if (!arst_n) begin
			present = 1'b0;
		end else if (start && !taken) begin
			// A stalled item stays on the ports until it is taken.
			present = 1'b1;
			nxt = {pos_x, pos_y, pos_z, vel_x, vel_y, vel_z};
		end else if (gap_left > 0) begin
			gap_left--;
		end else if (state_q.size() != 0) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0)
					gap_left = $urandom_range(0, 12);
			end
			if (gap_left == 0) begin
				burst_left--;
				nxt = state_q.pop_front();
				present = 1'b1;
			end
		end
		if (present) begin
			{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z} <= nxt;
			start <= 1'b1;
		end else begin
			start <= 1'b0;
		end
	end

	// The monitor takes every result in the cycle that done marks it and
	// compares it with the oldest prediction.
	always @(posedge clk) begin
		invariants_t got;
		invariants_t want;
		if (arst_n && done) begin
			got = {energy, ang_mom_x, ang_mom_y, ang_mom_z,
				ecc_vec_x, ecc_vec_y, ecc_vec_z, fault};
			results_seen++;
			if (fault)
				faults_seen++;
			if (invariants_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: %h", $realtime, got);
			end else begin
				want = invariants_q.pop_front();
				if (got.energy !== want.energy || got.hx !== want.hx ||
					got.hy !== want.hy || got.hz !== want.hz ||
					got.ex !== want.ex || got.ey !== want.ey ||
					got.ez !== want.ez || got.fault !== want.fault) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: mismatch energy %h/%h h %h %h %h / %h %h %h",
							$realtime, got.energy, want.energy, got.hx, got.hy,
							got.hz, want.hx, want.hy, want.hz);
						$display("    ecc %h %h %h / %h %h %h fault %b/%b",
							got.ex, got.ey, got.ez, want.ex, want.ey, want.ez,
							got.fault, want.fault);
					end
				end
			end
		end
	end

	// The watchdog ends a run in which nothing moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d quiet cycles, %0d results outstanding",
				idle_cycles, invariants_q.size());
			$display("FAIL");
			$finish;
		end
	end

	// Register write through the APB-style port: setup, then access.
	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [63:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == ADDR_W'(8 * REG_GRAV_PARAM))
			mu_model = data[MU_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [31:0] near_orbit_pos();
		logic [31:0] m;
		m = $urandom_range(6_400_000, 42_000_000);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic logic [31:0] near_orbit_vel();
		logic [31:0] m;
		m = $urandom_range(0, 11_000 * 65_536);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	// Most random items look like real orbits so the energy and eccentricity
	// land in range; one in five are raw words that drive saturation and faults.
	task automatic queue_random_states(input int count);
		state_vec_t s;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 9))
				0, 1: s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
				2: begin
					s = {near_orbit_pos(), near_orbit_pos(), near_orbit_pos(),
						near_orbit_vel(), near_orbit_vel(), near_orbit_vel()};
					if ($urandom_range(0, 1)) s.py = '0;
					if ($urandom_range(0, 1)) s.pz = '0;
					if ($urandom_range(0, 1)) s.vx = '0;
					if ($urandom_range(0, 2) == 0) s.px = $urandom_range(0, 3);
				end
				default: s = {near_orbit_pos(), near_orbit_pos(), near_orbit_pos(),
					near_orbit_vel(), near_orbit_vel(), near_orbit_vel()};
			endcase
			state_q.push_back(s);
		end
	endtask

	// Let all queued items go and every result come back, then give the
	// pipeline its full latency before the parameter may change.
	task automatic drain();
		while (state_q.size() != 0 || start || invariants_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		phases_run++;
	endtask

	initial begin
		logic [31:0] maxp;
		logic [31:0] minn;
		maxp = 32'h7fff_ffff;
		minn = 32'h8000_0000;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset value of the parameter.
		state_q.push_back('0);                                           // zero radius
		state_q.push_back({32'd0, 32'd0, 32'd0, maxp, minn, maxp});      // zero radius, fast
		state_q.push_back({32'd6_778_000, 32'd0, 32'd0, 32'd0, 32'd7668 << 16, 32'd0});
		state_q.push_back({32'd0, -32'd42_164_000, 32'd0, 32'd3075 << 16, 32'd0, 32'd0});
		state_q.push_back({32'd7_000_000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}); // at rest
		state_q.push_back({maxp, maxp, maxp, maxp, maxp, maxp});
		state_q.push_back({minn, minn, minn, minn, minn, minn});
		state_q.push_back({maxp, minn, maxp, minn, maxp, minn});
		state_q.push_back({minn, maxp, minn, minn, maxp, minn});
		state_q.push_back({32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});  // energy floor
		state_q.push_back({32'd1, 32'd0, 32'd0, 32'd0, maxp, 32'd0});   // energy floor, fast
		state_q.push_back({-32'd1, 32'd0, 32'd0, 32'd0, minn, 32'd0});
		state_q.push_back({32'd0, 32'd0, -32'd1, minn, 32'd0, 32'd1});
		state_q.push_back({32'd6_778_000, 32'd0, 32'd0, 32'd0, 32'd10_844 << 16, 32'd0});
		queue_random_states(RANDOM_ITEMS);
		drain();

		// Smallest parameter: ecc saturation dominates; the energy floor is reached only at zero radius.
		apb_write(ADDR_W'(8 * REG_GRAV_PARAM), 64'd1);
		state_q.push_back({32'd6_778_000, 32'd0, 32'd0, 32'd0, 32'd7668 << 16, 32'd0});
		queue_random_states(RANDOM_ITEMS);
		drain();

		// A zero parameter acts as one.
		apb_write(ADDR_W'(8 * REG_GRAV_PARAM), 64'd0);
		queue_random_states(RANDOM_ITEMS / 2);
		drain();

		// All ones: the top bit is dropped, leaving the largest parameter.
		apb_write(ADDR_W'(8 * REG_GRAV_PARAM), 64'hffff_ffff_ffff_ffff);
		state_q.push_back({32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
		queue_random_states(RANDOM_ITEMS);
		drain();

		// Earth value again, then a write to an unused address changes nothing.
		apb_write(ADDR_W'(8 * REG_GRAV_PARAM), 64'd398_600_441_800_000);
		apb_write(ADDR_W'(8), {$urandom, $urandom});
		queue_random_states(RANDOM_ITEMS);
		drain();

		// Random parameters over the whole range.
		for (int p = 0; p < 3; p++) begin
			apb_write(ADDR_W'(8 * REG_GRAV_PARAM),
				{$urandom, $urandom} >> $urandom_range(0, 40));
			queue_random_states(RANDOM_ITEMS / 2);
			drain();
		end

		$display("%0d state vectors in %0d parameter settings; %0d results, %0d faulted",
			items_sent, phases_run, results_seen, faults_seen);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0 && invariants_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/oifs_pkg.sv
hw/rtl/orbit_invariants_from_state_core.sv
hw/rtl/oifs_checker.sv
dv/tb.sv
